>>> hw/rtl/led_level_ramp_sequencer_unit_defines.svh
// Assertion macros used by the top RTL file of the level ramp sequencer.
`ifndef LED_LEVEL_RAMP_SEQUENCER_UNIT_DEFINES_SVH
`define LED_LEVEL_RAMP_SEQUENCER_UNIT_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define LLRS_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequence holds in the same cycle as the cause.
`define LLRS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequence holds in the cycle after the cause.
`define LLRS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/llrs_pkg.sv
package llrs_pkg;

  localparam int LEVEL_BITS   = 16;
  localparam int TICK_BITS    = 16;
  localparam int DIV_CNT_BITS = $clog2(LEVEL_BITS + 1);

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [1:0] CFG_PROGRAM_LENGTH = 2'd0;
  localparam logic [1:0] CFG_PREDELAY_TICKS = 2'd1;
  localparam logic [1:0] CFG_REPEAT_ENABLE  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  step_index;
    logic [15:0] step_level;
    logic [15:0] step_ticks;
  } in_word_t;

  typedef struct packed {
    logic [15:0] level;
    logic [3:0]  step_position;
    logic        in_transition;
    logic        program_exhausted;
  } out_word_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic [TICK_BITS-1:0]  ticks;
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LVL,
    ST_RD_DUR,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_e;

endpackage

>>> hw/rtl/llrs_store.sv
module llrs_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  llrs_pkg::step_t    wr_data_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output llrs_pkg::step_t    rd_data_o
);

  llrs_pkg::step_t mem_q [DEPTH];
  llrs_pkg::step_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> hw/rtl/llrs_div.sv
module llrs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [llrs_pkg::LEVEL_BITS:0] dividend_i,
  input  logic [llrs_pkg::TICK_BITS-1:0] divisor_i,
  output logic                          done_o,
  output logic [llrs_pkg::LEVEL_BITS:0] quotient_o
);

  localparam int LB = llrs_pkg::LEVEL_BITS;
  localparam int TB = llrs_pkg::TICK_BITS;

  logic [llrs_pkg::DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic                              neg_q, neg_d;
  logic [LB-1:0]                     quo_q, quo_d;
  logic [TB:0]                       rem_q, rem_d;
  logic [TB-1:0]                     dvs_q, dvs_d;
  logic [LB:0]                       mag;
  logic [TB:0]                       trial;
  logic [TB:0]                       shifted;

  always_comb begin
    mag     = dividend_i[LB] ? (~dividend_i + 1'b1) : dividend_i;
    shifted = {rem_q[TB-1:0], quo_q[LB-1]};
    trial   = shifted - {1'b0, dvs_q};
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    neg_d   = neg_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = llrs_pkg::DIV_CNT_BITS'(LB);
      neg_d  = dividend_i[LB];
      quo_d  = mag[LB-1:0];
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = trial;
        quo_d = {quo_q[LB-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[LB-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == llrs_pkg::DIV_CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~{1'b0, quo_q} + 1'b1) : {1'b0, quo_q};

endmodule

>>> hw/rtl/led_level_ramp_sequencer_unit.sv
// The sequencer takes one word at a time and answers each with one word. A write, restart,
// unused code or tick that neither ramps nor fetches a step goes from acceptance straight to
// the state that loads the output register, and the next word is accepted after that. A tick
// that ramps goes through the bit-serial divider: one state starts it, it makes the 16
// quotient bits one after another, the quotient is taken into the level, and the output
// register is loaded; the next word is accepted once the sequencer is back in idle. A tick
// that also fetches the next step first reads the level and then the ticks of that step from
// the program store; a fetched step with zero ticks does not ramp. The output register is only
// loaded once it is free. A finished result waits there while the next word is accepted.
`include "led_level_ramp_sequencer_unit_defines.svh"

module led_level_ramp_sequencer_unit #(
  parameter int MAX_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  llrs_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output llrs_pkg::out_word_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int HW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int LB = llrs_pkg::LEVEL_BITS;
  localparam int TB = llrs_pkg::TICK_BITS;

  llrs_pkg::state_e    state_q, state_d;
  logic [HW-1:0]       head_q, head_d;
  logic [4:0]          steps_q, steps_d;
  logic [LB-1:0]       cur_q, cur_d;
  logic [LB-1:0]       tgt_q, tgt_d;
  logic [TB-1:0]       ticks_q, ticks_d;
  logic [4:0]          prog_len_q;
  logic [15:0]         predelay_q;
  logic                repeat_q;
  logic                out_valid_q, out_valid_d;
  llrs_pkg::out_word_t out_q, out_d;

  logic                in_fire;
  logic [4:0]          eff_len;
  logic [HW:0]         head_inc;
  logic [HW-1:0]       head_next;
  logic [4:0]          steps_new;
  logic                wr_en;
  logic                rd_en;
  logic [HW-1:0]       rd_addr;
  llrs_pkg::step_t     wr_data;
  llrs_pkg::step_t     rd_data;
  logic                div_start;
  logic                div_done;
  logic [LB:0]         diff;
  logic [LB:0]         delta;
  logic [LB:0]         sum;

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= '0;
      predelay_q <= '0;
      repeat_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        llrs_pkg::CFG_PROGRAM_LENGTH: prog_len_q <= cfg_data_i[4:0];
        llrs_pkg::CFG_PREDELAY_TICKS: predelay_q <= cfg_data_i;
        llrs_pkg::CFG_REPEAT_ENABLE:  repeat_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_len   = (32'(prog_len_q) > MAX_STEPS) ? 5'(MAX_STEPS) : prog_len_q;
    head_inc  = {1'b0, head_q} + 1'b1;
    head_next = ((32'(head_inc) >= 32'(eff_len)) || (32'(head_inc) >= MAX_STEPS)) ?
                '0 : head_inc[HW-1:0];
    steps_new = repeat_q ? steps_q : (steps_q - 1'b1);
    wr_en     = in_fire && (in_data_i.command == llrs_pkg::CMD_WRITE) &&
                (32'(in_data_i.step_index) < MAX_STEPS);
    wr_data   = '{level: LB'(in_data_i.step_level), ticks: TB'(in_data_i.step_ticks)};
    diff      = {1'b0, tgt_q} - {1'b0, cur_q};
    sum       = {1'b0, cur_q} + delta;
  end

  llrs_store #(
    .DEPTH (MAX_STEPS),
    .AW    (HW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (HW'(in_data_i.step_index)),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  llrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff),
    .divisor_i  (ticks_q),
    .done_o     (div_done),
    .quotient_o (delta)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    steps_d     = steps_q;
    cur_d       = cur_q;
    tgt_d       = tgt_q;
    ticks_d     = ticks_q;
    in_ready_o  = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      llrs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = llrs_pkg::ST_DONE;
          if (in_data_i.command == llrs_pkg::CMD_TICK) begin
            if (ticks_q != '0) begin
              state_d = llrs_pkg::ST_DIV_GO;
            end else if (steps_q != '0) begin
              head_d  = head_next;
              steps_d = steps_new;
              if (steps_new != '0) begin
                rd_en   = 1'b1;
                state_d = llrs_pkg::ST_RD_LVL;
              end else begin
                ticks_d = '0;
                cur_d   = tgt_q;
              end
            end else begin
              cur_d = '0;
              tgt_d = '0;
            end
          end else if (in_data_i.command == llrs_pkg::CMD_RESTART) begin
            head_d  = '0;
            steps_d = eff_len;
            tgt_d   = cur_q;
            ticks_d = TB'(predelay_q);
          end
        end
      end
      llrs_pkg::ST_RD_LVL: begin
        tgt_d   = rd_data.level;
        rd_en   = 1'b1;
        state_d = llrs_pkg::ST_RD_DUR;
      end
      llrs_pkg::ST_RD_DUR: begin
        ticks_d = rd_data.ticks;
        state_d = (rd_data.ticks != '0) ? llrs_pkg::ST_DIV_GO : llrs_pkg::ST_DONE;
      end
      llrs_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = llrs_pkg::ST_DIV_WAIT;
      end
      llrs_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          cur_d   = sum[LB-1:0];
          ticks_d = ticks_q - 1'b1;
          state_d = llrs_pkg::ST_DONE;
        end
      end
      llrs_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          out_d.level             = 16'(cur_q);
          out_d.step_position     = 4'(head_q);
          out_d.in_transition     = (ticks_q != '0);
          out_d.program_exhausted = (steps_q == '0);
          state_d                 = llrs_pkg::ST_IDLE;
        end
      end
      default: state_d = llrs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= llrs_pkg::ST_IDLE;
      head_q      <= '0;
      steps_q     <= '0;
      cur_q       <= '0;
      tgt_q       <= '0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      steps_q     <= steps_d;
      cur_q       <= cur_d;
      tgt_q       <= tgt_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LLRS_ASSERT_ALWAYS(a_head_in_range, clk_i, rst_ni, 32'(head_q) < MAX_STEPS, "head out of range")
  `LLRS_ASSERT_IMP(a_div_done_in_wait, clk_i, rst_ni, div_done, state_q == llrs_pkg::ST_DIV_WAIT, "divider result outside wait")
  `LLRS_ASSERT_NEXT(a_ramp_tick_divides, clk_i, rst_ni, in_fire && (in_data_i.command == llrs_pkg::CMD_TICK) && (ticks_q != '0), state_q == llrs_pkg::ST_DIV_GO, "ramp tick did not start divider")
  `LLRS_ASSERT_NEXT(a_ticks_count_down, clk_i, rst_ni, (state_q == llrs_pkg::ST_DIV_WAIT) && div_done, ticks_q == TB'($past(ticks_q) - 1'b1), "ticks left not decremented")

endmodule
